// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file aocs_checker.sv
// each macro samples on the rising edge of clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while rst is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/aocs_pkg.sv =====
// shared constants for the airspeed offset calibration and root core
// no dependencies
package aocs_pkg;

  localparam int CAL_SAMPLES_DEF = 64;
  localparam int SAMPLE_W        = 16;
  localparam int SPEED_W         = 20;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MAX  = 2'd2;

  localparam logic [CFG_W-1:0] VALUE_SCALE_RST = 16'd4096;
  localparam logic [CFG_W-1:0] OFFSET_MIN_RST  = 16'd0;
  localparam logic [CFG_W-1:0] OFFSET_MAX_RST  = 16'hFFFF;

  // control between the core and the root unit
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] diff;
    logic [CFG_W-1:0]    scale;
  } root_req_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] root;
  } root_rsp_t;

endpackage

// ===== rtl/aocs_root.sv =====
// bit-serial scale multiply and digit-by-digit square root
// uses aocs_pkg; result = isqrt((diff * scale * scale) >> 8)
module aocs_root (
  input  logic                clk,
  input  logic                rst,
  input  aocs_pkg::root_req_t req,
  output aocs_pkg::root_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_SQRT = 2'd3;

  logic [1:0]  state;
  logic [4:0]  cnt;
  logic [47:0] acc;
  logic [47:0] mcand;
  logic [15:0] mplier;
  logic [15:0] scale;
  logic [39:0] x;
  logic [21:0] rem;
  logic [19:0] root;
  logic        done;

  logic [47:0] acc_next;
  logic [23:0] rem_sh;
  logic [23:0] trial;

  assign acc_next = mplier[0] ? acc + mcand : acc;
  assign rem_sh   = {rem, x[39:38]};
  assign trial    = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_SQRT) && (cnt == 5'd19);
      case (state)
        S_IDLE: begin
          if (req.start) begin
            acc    <= '0;
            mcand  <= {32'd0, req.diff};
            mplier <= req.scale;
            scale  <= req.scale;
            cnt    <= '0;
            state  <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (cnt == 5'd15) begin
            mcand  <= acc_next;
            acc    <= '0;
            mplier <= scale;
            cnt    <= '0;
            state  <= S_MUL2;
          end else begin
            acc    <= acc_next;
            mcand  <= {mcand[46:0], 1'b0};
            mplier <= {1'b0, mplier[15:1]};
            cnt    <= cnt + 5'd1;
          end
        end
        S_MUL2: begin
          if (cnt == 5'd15) begin
            x     <= acc_next[47:8];
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            acc    <= acc_next;
            mcand  <= {mcand[46:0], 1'b0};
            mplier <= {1'b0, mplier[15:1]};
            cnt    <= cnt + 5'd1;
          end
        end
        S_SQRT: begin
          // one root bit per cycle
          x   <= {x[37:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (rem_sh >= trial) begin
            rem  <= 22'(rem_sh - trial);
            root <= {root[18:0], 1'b1};
          end else begin
            rem  <= rem_sh[21:0];
            root <= {root[18:0], 1'b0};
          end
          if (cnt == 5'd19) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

// ===== rtl/airspeed_offset_calibrate_sqrt_core.sv =====
// calibration sample: stored, then S_FIN raises m_tvalid and s_tready once the output is free
// calibration end: the result follows the trigger after one rank pass over the sample memory
//   per stored sample and a serial divide
// running sample: the result follows the two serial multiplies by scale, the serial root in
//   aocs_root and the handoff to S_FIN; below offset as above
// one item in flight; rst (synchronous) restarts calibration, offset 0, registers to defaults
module airspeed_offset_calibrate_sqrt_core #(
  parameter int CAL_SAMPLES = aocs_pkg::CAL_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // [15:0] raw_sample
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,   // [19:0] speed, [35:20] zero_offset, pad
  output logic                        m_tuser,   // [0] speed_valid
  input  logic                        cfg_we,
  input  logic [aocs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aocs_pkg::CFG_W-1:0]  cfg_data
);

  localparam int IW    = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
  localparam int CW    = $clog2(CAL_SAMPLES + 1);
  localparam int SUMW  = 16 + CW;
  localparam int DCW   = $clog2(SUMW + 1);
  localparam int DROP  = (CAL_SAMPLES > 10) ? CAL_SAMPLES / 4 : 0;
  localparam int LO    = DROP;
  localparam int HI    = CAL_SAMPLES - DROP;
  localparam int KEEP  = HI - LO;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADI = 3'd1;
  localparam logic [2:0] S_GETI  = 3'd2;
  localparam logic [2:0] S_RANK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]  state;
  logic [15:0] value_scale;
  logic [15:0] offset_min;
  logic [15:0] offset_max;
  logic [CW-1:0] cal_count;
  logic        calibrating;
  logic [15:0] offset_reg;
  logic        res_valid;
  logic [19:0] res_speed;

  logic [15:0] mem [CAL_SAMPLES];
  logic [15:0] rd;
  logic [IW-1:0] raddr;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] jd;
  logic [15:0] vi;
  logic [CW-1:0] rank;
  logic [CW-1:0] rank_next;
  logic [SUMW-1:0] sum;
  logic [CW:0]   drem;
  logic [CW+1:0] drem_sh;
  logic [DCW-1:0] dcnt;
  logic [15:0] avg;
  logic [15:0] avg_lo;

  aocs_pkg::root_req_t req;
  aocs_pkg::root_rsp_t rsp;

  logic accept;
  logic out_free;
  logic fin_load;
  logic less;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign fin_load = (state == S_FIN) && out_free;

  assign raddr     = (state == S_LOADI) ? i : j;
  assign less      = (rd < vi) || ((rd == vi) && (jd < i));
  assign rank_next = rank + CW'(less);
  assign drem_sh   = {drem, sum[SUMW-1]};
  assign avg       = sum[15:0];
  assign avg_lo    = (avg < offset_min) ? offset_min : avg;

  assign req.start = accept && !calibrating && (s_tdata >= offset_reg);
  assign req.diff  = s_tdata - offset_reg;
  assign req.scale = value_scale;

  aocs_root u_root (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (accept && calibrating && (cal_count < CW'(CAL_SAMPLES))) begin
      mem[cal_count[IW-1:0]] <= s_tdata;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_scale <= aocs_pkg::VALUE_SCALE_RST;
      offset_min  <= aocs_pkg::OFFSET_MIN_RST;
      offset_max  <= aocs_pkg::OFFSET_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aocs_pkg::CFG_VALUE_SCALE: value_scale <= cfg_data;
        aocs_pkg::CFG_OFFSET_MIN:  offset_min  <= cfg_data;
        aocs_pkg::CFG_OFFSET_MAX:  offset_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cal_count   <= '0;
      calibrating <= 1'b1;
      offset_reg  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (fin_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_speed <= '0;
            res_valid <= !calibrating;
            if (calibrating) begin
              if (cal_count < CW'(CAL_SAMPLES)) begin
                cal_count <= cal_count + CW'(1);
                state     <= S_FIN;
              end else begin
                i     <= '0;
                sum   <= '0;
                state <= S_LOADI;
              end
            end else if (req.start) begin
              state <= S_ROOT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_LOADI: begin
          j     <= '0;
          state <= S_GETI;
        end
        S_GETI: begin
          vi    <= rd;
          rank  <= '0;
          jd    <= j;
          j     <= j + IW'(1);
          state <= S_RANK;
        end
        S_RANK: begin
          // rank of sample i among all stored, ties broken by position
          rank <= rank_next;
          jd   <= j;
          j    <= j + IW'(1);
          if (jd == IW'(CAL_SAMPLES - 1)) begin
            if ((rank_next >= CW'(LO)) && (rank_next < CW'(HI))) begin
              sum <= sum + SUMW'(vi);
            end
            if (i == IW'(CAL_SAMPLES - 1)) begin
              drem  <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end else begin
              i     <= i + IW'(1);
              state <= S_LOADI;
            end
          end
        end
        S_DIV: begin
          // restoring divide, quotient bits shift into sum
          dcnt <= dcnt + DCW'(1);
          if (drem_sh >= (CW+2)'(KEEP)) begin
            drem <= (CW+1)'(drem_sh - (CW+2)'(KEEP));
            sum  <= {sum[SUMW-2:0], 1'b1};
          end else begin
            drem <= drem_sh[CW:0];
            sum  <= {sum[SUMW-2:0], 1'b0};
          end
          if (dcnt == DCW'(SUMW)) begin
            offset_reg  <= (avg_lo > offset_max) ? offset_max : avg_lo;
            calibrating <= 1'b0;
            state       <= S_FIN;
          end
        end
        S_ROOT: begin
          if (rsp.done) begin
            res_speed <= rsp.root;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tdata  <= {4'd0, offset_reg, res_speed};
            m_tuser  <= res_valid;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/aocs_checker.sv =====
// port-level checks for the airspeed core, bound to the top level
// uses assert_macros.svh
`include "assert_macros.svh"

module aocs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_cal_zero, m_tvalid && !m_tuser |-> m_tdata[19:0] == 20'd0, "speed set while calibrating")
  `ASSERT_CLK(a_busy, s_tvalid && s_tready |=> !s_tready, "second transfer taken while busy")
  `ASSERT_ALWAYS(a_rst_out, rst |=> !m_tvalid && s_tready, "outputs not cleared by reset")

endmodule

bind airspeed_offset_calibrate_sqrt_core aocs_checker u_aocs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
